### rtl/position_table_bilinear_resample_assert.svh
// Assertion macros for the position table resampler checker.
`ifndef POSITION_TABLE_BILINEAR_RESAMPLE_ASSERT_SVH
`define POSITION_TABLE_BILINEAR_RESAMPLE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define PBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define PBR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pbr_pkg.sv
// Shared types, constants and the divider step for the position table resampler.
`default_nettype none
package pbr_pkg;

  localparam int IDX_W      = 6;
  localparam int DIV_CYCLES = 4;
  localparam int DIV_STEPS  = 6;
  localparam int QW         = DIV_CYCLES * DIV_STEPS;
  localparam int FRAC_W     = 16;
  localparam int VAL_W      = 16;
  localparam int OUTQ_DEPTH = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN = 4'd3;

  typedef struct packed {
    logic [5:0] side;
    logic [9:0] rows;
    logic [9:0] cols;
    logic [6:0] hid;
  } cfg_t;

  typedef struct packed {
    logic              query;
    logic              wr;
    logic              bad;
    logic [5:0]        dim;
    logic [IDX_W-1:0]  y0;
    logic [IDX_W-1:0]  y1;
    logic [IDX_W-1:0]  x0;
    logic [IDX_W-1:0]  x1;
    logic [FRAC_W-1:0] fy;
    logic [FRAC_W-1:0] fx;
    logic [VAL_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [9:0]    rem;
    logic [QW-1:0] sh;
  } div_t;

  // Restoring division, DIV_STEPS quotient bits; dividend bits leave sh at the top,
  // quotient bits enter at the bottom.
  function automatic div_t div_steps(div_t s, logic [9:0] den);
    div_t        r;
    logic [10:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.sh[QW-1]};
      r.sh = {r.sh[QW-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        r.sh[0] = 1'b1;
      end
      r.rem = t[9:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/pbr_in_if.sv
// Input channel: one load or query word.
`default_nettype none
interface pbr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  table_row;
  logic [4:0]  table_col;
  logic [5:0]  dim_index;
  logic signed [15:0] table_value;
  logic [9:0]  grid_y;
  logic [9:0]  grid_x;

  modport source (output valid, operation, table_row, table_col, dim_index, table_value,
                  grid_y, grid_x, input ready);
  modport sink (input valid, operation, table_row, table_col, dim_index, table_value,
                grid_y, grid_x, output ready);
endinterface
`default_nettype wire

### rtl/pbr_out_if.sv
// Result channel: one resampled value word.
`default_nettype none
interface pbr_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] embed_value;
  logic        bad_query;

  modport source (output valid, embed_value, bad_query, input ready);
  modport sink (input valid, embed_value, bad_query, output ready);
endinterface
`default_nettype wire

### rtl/pbr_cfg_if.sv
// Configuration write channel: register index and data.
`default_nettype none
interface pbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/pbr_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module pbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

### rtl/pbr_map.sv
// Coordinate mapper: bounds check and align-corners division for both axes.
`default_nettype none
module pbr_map #(
  parameter int MAX_SIDE   = 32,
  parameter int VECTOR_DIM = 64,
  parameter int MAX_GRID   = 1023
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pbr_pkg::cfg_t cfg,
  pbr_in_if.sink             req,
  output logic               m_valid,
  input  wire logic          m_ready,
  output pbr_pkg::item_t     m_item
);
  logic [6:0] side_c;
  logic [5:0] sm1_c;
  logic [9:0] rows_c, cols_c;
  logic       bad_c, wr_c, take;
  logic [15:0] num_y, num_x;

  logic        busy;
  logic [2:0]  cnt;
  logic        query, bad, wr, zy, zx;
  logic [5:0]  dim, sm1;
  logic [4:0]  row, col;
  logic [15:0] value;
  logic [9:0]  den_y, den_x;
  pbr_pkg::div_t dy, dx, ny, nx;

  function automatic logic [pbr_pkg::IDX_W-1:0] lo_of(logic [7:0] qi, logic z,
                                                      logic [5:0] m);
    logic [7:0] v;
    v = z ? 8'd0 : qi;
    if (v > {2'b0, m}) v = {2'b0, m};
    return pbr_pkg::IDX_W'(v);
  endfunction

  always_comb begin
    side_c = (cfg.side == 6'd0) ? 7'd1 :
             ((int'(cfg.side) > MAX_SIDE) ? 7'(MAX_SIDE) : {1'b0, cfg.side});
    sm1_c  = 6'(side_c - 7'd1);
    rows_c = (int'(cfg.rows) > MAX_GRID) ? 10'(MAX_GRID) : cfg.rows;
    cols_c = (int'(cfg.cols) > MAX_GRID) ? 10'(MAX_GRID) : cfg.cols;
    bad_c  = (req.grid_y >= rows_c) || (req.grid_x >= cols_c) ||
             (int'(req.dim_index) >= ((int'(cfg.hid) > VECTOR_DIM) ? VECTOR_DIM
                                                                   : int'(cfg.hid)));
    wr_c   = (int'(req.table_row) < MAX_SIDE) && (int'(req.table_col) < MAX_SIDE) &&
             (int'(req.dim_index) < VECTOR_DIM);
    num_y  = 16'(req.grid_y) * 16'(sm1_c);
    num_x  = 16'(req.grid_x) * 16'(sm1_c);
  end

  assign ny = pbr_pkg::div_steps(dy, den_y);
  assign nx = pbr_pkg::div_steps(dx, den_x);

  assign m_valid   = busy && (cnt == 3'd1);
  assign req.ready = !busy || (m_valid && m_ready);
  assign take      = req.valid && req.ready;

  always_comb begin
    logic [pbr_pkg::IDX_W-1:0] ly, lx;
    ly = lo_of(ny.sh[23:16], zy, sm1);
    lx = lo_of(nx.sh[23:16], zx, sm1);
    m_item.query = query;
    m_item.wr    = wr;
    m_item.bad   = bad;
    m_item.dim   = dim;
    m_item.value = value;
    m_item.fy    = zy ? 16'd0 : ny.sh[15:0];
    m_item.fx    = zx ? 16'd0 : nx.sh[15:0];
    if (query) begin
      m_item.y0 = ly;
      m_item.x0 = lx;
      m_item.y1 = (ly < sm1) ? ly + 1'b1 : sm1;
      m_item.x1 = (lx < sm1) ? lx + 1'b1 : sm1;
    end else begin
      m_item.y0 = pbr_pkg::IDX_W'(row);
      m_item.x0 = pbr_pkg::IDX_W'(col);
      m_item.y1 = pbr_pkg::IDX_W'(row);
      m_item.x1 = pbr_pkg::IDX_W'(col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= req.operation ? 3'(pbr_pkg::DIV_CYCLES) : 3'd1;
    end else if (m_valid && m_ready) begin
      busy <= 1'b0;
    end else if (busy && cnt > 3'd1) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      query  <= req.operation;
      bad    <= bad_c;
      wr     <= wr_c;
      dim    <= req.dim_index;
      row    <= req.table_row;
      col    <= req.table_col;
      value  <= req.table_value;
      sm1    <= sm1_c;
      zy     <= (rows_c <= 10'd1);
      zx     <= (cols_c <= 10'd1);
      den_y  <= rows_c - 10'd1;
      den_x  <= cols_c - 10'd1;
      dy.rem <= {2'b0, num_y[15:8]};
      dy.sh  <= {num_y[7:0], 16'd0};
      dx.rem <= {2'b0, num_x[15:8]};
      dx.sh  <= {num_x[7:0], 16'd0};
    end else if (busy && cnt > 3'd1) begin
      dy <= ny;
      dx <= nx;
    end
  end
endmodule
`default_nettype wire

### rtl/pbr_fetch.sv
// Table fetch and blend: four reads per query from the table RAM, then two lerp stages.
`default_nettype none
module pbr_fetch #(
  parameter int MAX_SIDE   = 32,
  parameter int VECTOR_DIM = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           m_valid,
  output logic                m_ready,
  input  wire pbr_pkg::item_t m_item,
  input  wire logic           credit_ok,
  output logic                q_take,
  output logic                push,
  output logic signed [15:0]  push_value,
  output logic                push_bad
);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE * VECTOR_DIM;
  localparam int AW    = $clog2(DEPTH);

  pbr_pkg::item_t it;
  logic        busy, last, take;
  logic [1:0]  ph;
  logic [pbr_pkg::IDX_W-1:0] ar, ac;
  logic [AW-1:0] addr;
  logic [15:0] rdata;

  logic        s1v, s1bad, s2v, s2bad, s3v, s3bad;
  logic [1:0]  s1ph;
  logic [15:0] s1fx, s1fy, s2fy;
  logic signed [15:0] a, c;
  logic signed [32:0] top, bot, lerp_n;
  logic signed [16:0] d1;
  logic signed [33:0] p1, d2;
  logic signed [50:0] p2, acc_n, acc, sum;
  logic signed [18:0] r;

  assign last    = busy && (!it.query || ph == 2'd3);
  assign m_ready = (!busy || last) && (!m_item.query || credit_ok);
  assign take    = m_valid && m_ready;
  assign q_take  = take && m_item.query;

  always_comb begin
    case (ph)
      2'd0:    begin ar = it.y0; ac = it.x0; end
      2'd1:    begin ar = it.y0; ac = it.x1; end
      2'd2:    begin ar = it.y1; ac = it.x0; end
      default: begin ar = it.y1; ac = it.x1; end
    endcase
    addr = AW'((int'(ar) * MAX_SIDE + int'(ac)) * VECTOR_DIM + int'(it.dim));
  end

  pbr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .en    (busy),
    .we    (busy && !it.query && it.wr),
    .addr  (addr),
    .wdata (it.value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= 2'd0;
    end else if (take) begin
      busy <= 1'b1;
      ph   <= 2'd0;
    end else if (last) begin
      busy <= 1'b0;
    end else if (busy) begin
      ph <= ph + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) it <= m_item;
  end

  // Row and column lerp: a + (b - a) * f, exact; then round, saturate and zero bad queries.
  always_comb begin
    d1     = $signed({rdata[15], rdata}) - 17'(s1ph == 2'd1 ? a : c);
    p1     = d1 * $signed({1'b0, s1fx});
    lerp_n = 33'((34'(s1ph == 2'd1 ? a : c) <<< 16) + p1);
    d2     = 34'(bot) - 34'(top);
    p2     = d2 * $signed({1'b0, s2fy});
    acc_n  = (51'(top) <<< 16) + p2;
    sum    = acc + (51'sd1 <<< 31);
    r      = sum[50:32];
    if (r > 19'sd32767)       push_value = 16'sh7fff;
    else if (r < -19'sd32768) push_value = 16'sh8000;
    else                      push_value = 16'(r);
    if (s3bad) push_value = 16'sd0;
  end

  assign push     = s3v;
  assign push_bad = s3bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else begin
      s1v <= busy && it.query;
      s2v <= s1v && (s1ph == 2'd3);
      s3v <= s2v;
    end
  end

  always_ff @(posedge clk) begin
    s1ph  <= ph;
    s1fx  <= it.fx;
    s1fy  <= it.fy;
    s1bad <= it.bad;
    if (s1v) begin
      case (s1ph)
        2'd0:    a <= $signed(rdata);
        2'd1:    top <= lerp_n;
        2'd2:    c <= $signed(rdata);
        default: begin
          bot   <= lerp_n;
          s2fy  <= s1fy;
          s2bad <= s1bad;
        end
      endcase
    end
    acc   <= acc_n;
    s3bad <= s2bad;
  end
endmodule
`default_nettype wire

### rtl/pbr_outq.sv
// Result queue: holds finished words until the sink takes them.
`default_nettype none
module pbr_outq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [15:0] push_value,
  input  wire logic        push_bad,
  pbr_out_if.source        rsp
);
  localparam int D  = pbr_pkg::OUTQ_DEPTH;
  localparam int PW = $clog2(D);

  logic [16:0]   mem [D];
  logic [PW-1:0] head, tail;
  logic [PW:0]   count;
  logic          pop;

  assign rsp.valid       = (count != '0);
  assign rsp.embed_value = $signed(mem[head][16:1]);
  assign rsp.bad_query   = mem[head][0];
  assign pop             = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop)  head <= head + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[tail] <= {push_value, push_bad};
  end
endmodule
`default_nettype wire

### rtl/position_table_bilinear_resample.sv
// A query passes the divider of the mapper, the four reads of the table RAM, the lerp
// stages and the result queue. Queries are paced by the four reads of the single-port
// table RAM and the credit check; a load uses that port once and gives no result.
// The mapper divides for one query while the fetch stage reads for the previous one.
// Reset (synchronous, active high) clears control state and loads register defaults;
// the table RAM keeps its contents and needs no clearing pass.
`default_nettype none
module position_table_bilinear_resample #(
  parameter int MAX_SIDE   = 32,
  parameter int VECTOR_DIM = 64,
  parameter int MAX_GRID   = 1023
) (
  input wire logic  clk,
  input wire logic  rst,
  pbr_in_if.sink    req,
  pbr_out_if.source rsp,
  pbr_cfg_if.sink   cfg
);
  localparam int CW = $clog2(pbr_pkg::OUTQ_DEPTH) + 1;

  pbr_pkg::cfg_t  regs;
  pbr_pkg::item_t m_item;
  logic           m_valid, m_ready;
  logic           q_take, push, push_bad, credit_ok;
  logic [15:0]    push_value;
  logic [CW-1:0]  inflight;

  // Configuration: always ready, unknown indexes dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.side <= 6'd32;
      regs.rows <= 10'd32;
      regs.cols <= 10'd32;
      regs.hid  <= 7'd64;
    end else if (cfg.valid) begin
      case (cfg.index)
        pbr_pkg::REG_SIDE:   regs.side <= cfg.data[5:0];
        pbr_pkg::REG_ROWS:   regs.rows <= cfg.data;
        pbr_pkg::REG_COLS:   regs.cols <= cfg.data;
        pbr_pkg::REG_HIDDEN: regs.hid  <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // Credit: count queries between fetch start and delivery, so the result
  // queue always has room and the blend pipeline never has to stall.
  assign credit_ok = (int'(inflight) < pbr_pkg::OUTQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else     inflight <= inflight + CW'(q_take) - CW'(rsp.valid && rsp.ready);
  end

  // Map grid position onto the table.
  pbr_map #(.MAX_SIDE(MAX_SIDE), .VECTOR_DIM(VECTOR_DIM), .MAX_GRID(MAX_GRID)) u_map (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .req     (req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
  );

  // Read four neighbors (or write one entry) and blend.
  pbr_fetch #(.MAX_SIDE(MAX_SIDE), .VECTOR_DIM(VECTOR_DIM)) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_item     (m_item),
    .credit_ok  (credit_ok),
    .q_take     (q_take),
    .push       (push),
    .push_value (push_value),
    .push_bad   (push_bad)
  );

  // Hold finished words for the sink.
  pbr_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .push_bad   (push_bad),
    .rsp        (rsp)
  );
endmodule
`default_nettype wire

### rtl/pbr_check.sv
// Port checker for the resampler result channel, bound to the top level.
`default_nettype none
`include "position_table_bilinear_resample_assert.svh"
module pbr_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] embed_value,
  input wire logic        bad_query
);
  `PBR_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result word dropped while stalled")
  `PBR_ASSERT(a_stable, rsp_valid && !rsp_ready |=> $stable(embed_value) && $stable(bad_query), "stalled result word changed")
  `PBR_ASSERT(a_bad_zero, rsp_valid && bad_query |-> embed_value == 16'd0, "flagged query carries a value")
  `PBR_ASSERT_ALWAYS(a_rst_quiet, rst |=> !rsp_valid, "result word valid right after reset")
endmodule

bind position_table_bilinear_resample pbr_check u_check (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .embed_value (rsp.embed_value),
  .bad_query   (rsp.bad_query)
);
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the position table resampler: directed and random loads and queries.
module tb_top;

  typedef struct {
    logic        operation;
    logic [4:0]  table_row;
    logic [4:0]  table_col;
    logic [5:0]  dim_index;
    logic [15:0] table_value;
    logic [9:0]  grid_y;
    logic [9:0]  grid_x;
  } req_word_t;

  typedef struct {
    logic [15:0] embed_value;
    logic        bad_query;
  } rsp_word_t;

  localparam int T_SIDE = 32;
  localparam int T_DIM  = 64;
  localparam int T_GRID = 1023;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pbr_in_if  req();
  pbr_out_if rsp();
  pbr_cfg_if cfg();

  position_table_bilinear_resample dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow table and register copies.
  logic [15:0] shadow_table [0:T_SIDE*T_SIDE*T_DIM-1];
  logic [5:0]  side_reg;
  logic [9:0]  rows_reg, cols_reg;
  logic [6:0]  hid_reg;

  req_word_t pending_words[$];
  rsp_word_t expected_values[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        stall_all   = 1'b0;

  // Append one word to the driver queue.
  task automatic add_word(input req_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic int table_addr(int r, int c, int d);
    return (r * T_SIDE + c) * T_DIM + d;
  endfunction

  // Map one axis onto the table with align-corners scaling.
  function automatic void map_axis(input int pos, input int grid, input int side,
                                   output int lo, output int hi, output longint frac);
    longint num, den;
    lo = 0;
    frac = 0;
    if (grid > 1) begin
      num = longint'(pos) * (side - 1);
      den = grid - 1;
      lo = int'(num / den);
      frac = ((num % den) << 16) / den;
    end
    if (lo > side - 1) lo = side - 1;
    hi = (lo + 1 < side) ? lo + 1 : side - 1;
  endfunction

  function automatic longint entry(int r, int c, int d);
    return longint'($signed(shadow_table[table_addr(r, c, d)]));
  endfunction

  // Apply one word to the shadow state; queue the result word it causes.
  task automatic resample_predict(input req_word_t w);
    int side, rows, cols, hid, y0, y1, x0, x1;
    longint fy, fx, top, bot, acc, r;
    rsp_word_t res;
    if (w.operation == 1'b0) begin
      shadow_table[table_addr(w.table_row, w.table_col, w.dim_index)] = w.table_value;
      return;
    end
    side = (side_reg < 1) ? 1 : (side_reg > T_SIDE) ? T_SIDE : side_reg;
    rows = (rows_reg > T_GRID) ? T_GRID : rows_reg;
    cols = (cols_reg > T_GRID) ? T_GRID : cols_reg;
    hid  = (hid_reg > T_DIM) ? T_DIM : hid_reg;
    if (w.grid_y >= rows || w.grid_x >= cols || w.dim_index >= hid) begin
      res.embed_value = 16'd0;
      res.bad_query = 1'b1;
    end else begin
      map_axis(w.grid_y, rows, side, y0, y1, fy);
      map_axis(w.grid_x, cols, side, x0, x1, fx);
      top = entry(y0, x0, w.dim_index) * (65536 - fx) + entry(y0, x1, w.dim_index) * fx;
      bot = entry(y1, x0, w.dim_index) * (65536 - fx) + entry(y1, x1, w.dim_index) * fx;
      acc = top * (65536 - fy) + bot * fy;
      r = (acc + (64'sd1 <<< 31)) >>> 32;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      res.embed_value = r[15:0];
      res.bad_query = 1'b0;
    end
    expected_values.insert(expected_values.size(), res);
  endtask

  // Driver: bursts of words with random gaps; hold the word until accepted.
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        resample_predict(pending_words.pop_front());
      end
      if (!(req.valid && !req.ready)) begin
        if (gap_left > 0 || stall_all || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req.valid <= 1'b0;
        end else begin
          req.valid       <= 1'b1;
          req.operation   <= pending_words[0].operation;
          req.table_row   <= pending_words[0].table_row;
          req.table_col   <= pending_words[0].table_col;
          req.dim_index   <= pending_words[0].dim_index;
          req.table_value <= pending_words[0].table_value;
          req.grid_y      <= pending_words[0].grid_y;
          req.grid_x      <= pending_words[0].grid_x;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: check each result word against the oldest expectation.
  logic [3:0] stall_phase = 4'd0;
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 4'd1;
      rsp.ready <= (stall_phase < 4'd8) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (rsp.valid && rsp.ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch("unexpected word", rsp.embed_value, 0);
        end else begin
          want = expected_values.pop_front();
          if (rsp.embed_value !== want.embed_value)
            report_mismatch("embed_value", $signed(rsp.embed_value), $signed(want.embed_value));
          if (rsp.bad_query !== want.bad_query)
            report_mismatch("bad_query", rsp.bad_query, want.bad_query);
        end
      end
      // Count cycles with no accepted word on any channel.
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[position_table_bilinear_resample] ERROR");
        $finish;
      end
    end
  end

  function automatic req_word_t load_word(int r, int c, int d, int v);
    req_word_t w;
    w.operation = 1'b0;
    w.table_row = 5'(r);
    w.table_col = 5'(c);
    w.dim_index = 6'(d);
    w.table_value = 16'(v);
    w.grid_y = 10'($urandom);
    w.grid_x = 10'($urandom);
    return w;
  endfunction

  function automatic req_word_t query_word(int gy, int gx, int d);
    req_word_t w;
    w.operation = 1'b1;
    w.table_row = 5'($urandom);
    w.table_col = 5'($urandom);
    w.dim_index = 6'(d);
    w.table_value = 16'($urandom);
    w.grid_y = 10'(gy);
    w.grid_x = 10'(gx);
    return w;
  endfunction

  // Wait until the block has drained.
  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_values.size() != 0 || req.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write and wait for its acceptance; valid stays up.
  task automatic write_reg(input logic [3:0] idx, input int val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= 10'(val);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      pbr_pkg::REG_SIDE:   side_reg = 6'(val);
      pbr_pkg::REG_ROWS:   rows_reg = 10'(val);
      pbr_pkg::REG_COLS:   cols_reg = 10'(val);
      pbr_pkg::REG_HIDDEN: hid_reg  = 7'(val);
      default: ;
    endcase
  endtask

  task automatic configure(input int side, input int rows, input int cols, input int hid);
    write_reg(pbr_pkg::REG_SIDE, side);
    write_reg(pbr_pkg::REG_ROWS, rows);
    write_reg(pbr_pkg::REG_COLS, cols);
    write_reg(pbr_pkg::REG_HIDDEN, hid);
    cfg.valid <= 1'b0;
  endtask

  // Random query over the configured grid; mostly in range, some bad.
  function automatic req_word_t random_query(int side, int rows, int cols, int hid);
    int gy, gx, d;
    gy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, rows - 1);
    gx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, cols - 1);
    d  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, hid - 1);
    return query_word(gy, gx, d);
  endfunction

  // Fill every cell that a query can touch for the dims in use.
  task automatic fill_table(input int side, input int ndim);
    for (int r = 0; r < side; r++)
      for (int c = 0; c < side; c++)
        for (int d = 0; d < ndim; d++)
          add_word(load_word(r, c, d, $urandom));
  endtask

  typedef struct { int side; int rows; int cols; int hid; int nq; } phase_t;

  initial begin
    phase_t phases[5];
    int ext[4];
    phases[0] = '{4, 1023, 1, 2, 80};
    phases[1] = '{1, 7, 1023, 1, 50};
    phases[2] = '{3, 2, 5, 3, 100};
    phases[3] = '{2, 1, 2, 64, 50};
    phases[4] = '{5, 9, 13, 2, 60};
    ext = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    req.valid = 1'b0;
    req.operation = 1'b0;
    req.table_row = '0;
    req.table_col = '0;
    req.dim_index = '0;
    req.table_value = '0;
    req.grid_y = '0;
    req.grid_x = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    side_reg = 6'd32;
    rows_reg = 10'd32;
    cols_reg = 10'd32;
    hid_reg = 7'd64;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners of a full table at reset settings, extreme values,
    // plus bad-query cases.
    configure(32, 32, 32, 64);
    for (int i = 0; i < 4; i++) begin
      add_word(load_word(31 * (i & 1), 31 * (i >> 1), 63, ext[i]));
      add_word(load_word(31 * (i & 1), 31 * (i >> 1), 0, ext[3 - i]));
    end
    // Neighbors that the corner queries touch with zero weight.
    add_word(load_word(0, 1, 63, ext[2]));
    add_word(load_word(1, 0, 63, ext[3]));
    add_word(load_word(1, 1, 63, ext[0]));
    add_word(load_word(1, 31, 0, ext[1]));
    add_word(query_word(0, 0, 63));
    add_word(query_word(31, 31, 63));
    add_word(query_word(0, 31, 0));
    add_word(query_word(32, 0, 0));
    add_word(query_word(0, 1022, 0));
    wait_drained();
    // Hidden of 0 and grid of 0 flag everything.
    configure(63, 0, 1023, 0);
    add_word(query_word(0, 0, 0));
    add_word(query_word(1022, 1022, 63));
    wait_drained();
    // Side 2, grid 3: midpoints with saturating extremes.
    configure(2, 3, 3, 1);
    for (int i = 0; i < 4; i++) add_word(load_word(i & 1, i >> 1, 0, ext[i & 1]));
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) add_word(query_word(y, x, 0));
    wait_drained();

    // Random phases: load the used part of the table, then random mixed words.
    foreach (phases[p]) begin
      configure(phases[p].side, phases[p].rows, phases[p].cols, phases[p].hid);
      fill_table(phases[p].side, phases[p].hid > 4 ? 64 : phases[p].hid);
      for (int i = 0; i < phases[p].nq; i++) begin
        if ($urandom_range(0, 5) == 0)
          add_word(load_word($urandom_range(0, phases[p].side - 1),
                             $urandom_range(0, phases[p].side - 1),
                             $urandom_range(0, phases[p].hid - 1), $urandom));
        else
          add_word(random_query(phases[p].side, phases[p].rows,
                                phases[p].cols, phases[p].hid));
        // Hold the sender once until every result word is back.
        if (p == 2 && i == 60) begin
          stall_all = 1'b1;
          while (expected_values.size() != 0 || req.valid) @(posedge clk);
          stall_all = 1'b0;
        end
      end
      wait_drained();
    end

    if (error_count == 0 && expected_values.size() == 0) begin
      $display("[position_table_bilinear_resample] OK");
    end else begin
      $display("[position_table_bilinear_resample] ERROR");
    end
    $finish;
  end
endmodule
